[hw/rtl/ddo_pkg.sv]
// Package: shared constants, types and tables for the odometry block.
`timescale 1ns / 1ps
package ddo_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int POSITION_WIDTH = 32;
    localparam int ATAN_COUNT = 24;
    localparam int STEP_COUNT = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
    localparam int STEP_W = $clog2(ATAN_COUNT);
    localparam logic [21:0] ANG_GAIN = 22'd2670177;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    localparam logic [1:0] REG_HALF_TRACK = 2'd0;
    localparam logic [1:0] REG_TIME_STEP = 2'd1;
    localparam logic [1:0] REG_INV_RADIUS = 2'd2;

    typedef struct packed {
        logic        start;
        logic [33:0] ang;
    } cordic_req_t;

    typedef struct packed {
        logic               done;
        logic signed [33:0] cos_val;
        logic signed [33:0] sin_val;
    } cordic_rsp_t;

    function automatic logic signed [33:0] atan_entry(input logic [STEP_W-1:0] i);
        logic signed [33:0] r;
        begin
            case (i)
                5'd0: r = 34'sd536870912;
                5'd1: r = 34'sd316933406;
                5'd2: r = 34'sd167458907;
                5'd3: r = 34'sd85004756;
                5'd4: r = 34'sd42667331;
                5'd5: r = 34'sd21354465;
                5'd6: r = 34'sd10679838;
                5'd7: r = 34'sd5340245;
                5'd8: r = 34'sd2670163;
                5'd9: r = 34'sd1335087;
                5'd10: r = 34'sd667544;
                5'd11: r = 34'sd333772;
                5'd12: r = 34'sd166886;
                5'd13: r = 34'sd83443;
                5'd14: r = 34'sd41722;
                5'd15: r = 34'sd20861;
                5'd16: r = 34'sd10430;
                5'd17: r = 34'sd5215;
                5'd18: r = 34'sd2608;
                5'd19: r = 34'sd1304;
                5'd20: r = 34'sd652;
                5'd21: r = 34'sd326;
                5'd22: r = 34'sd163;
                5'd23: r = 34'sd81;
                default: r = 34'sd0;
            endcase
            return r;
        end
    endfunction
endpackage

[hw/rtl/ddo_cordic.sv]
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
`timescale 1ns / 1ps
module ddo_cordic
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ddo_pkg::cordic_req_t req,
    output ddo_pkg::cordic_rsp_t rsp
);
    logic                       busy_reg, busy_next;
    logic                       flip_reg, flip_next;
    logic [ddo_pkg::STEP_W-1:0] step_reg, step_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic done_reg, done_next;
    logic [31:0] a0;
    logic [31:0] af;
    logic        fl;
    logic signed [33:0] xs, ys, at;

    always_comb
    begin
        a0 = req.ang[31:0];
        fl = (a0[31:30] == 2'd1) || (a0[31:30] == 2'd2);
        af = fl ? (a0 + 32'h8000_0000) : a0;
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        at = ddo_pkg::atan_entry(step_reg);
        busy_next = busy_reg;
        flip_next = flip_reg;
        step_next = step_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            flip_next = fl;
            step_next = '0;
            x_next = ddo_pkg::CORDIC_X0;
            y_next = '0;
            z_next = {{2{af[31]}}, af};
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            step_next = step_reg + 1'b1;
            if (step_reg == ddo_pkg::STEP_W'(ddo_pkg::STEP_COUNT - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flip_reg <= flip_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign rsp.done = done_reg;
    assign rsp.cos_val = flip_reg ? -x_reg : x_reg;
    assign rsp.sin_val = flip_reg ? -y_reg : y_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> $past(busy_reg)) else $error("cordic done without run");
    a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> !busy_reg) else $error("cordic done while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg) else $error("cordic start lost");
endmodule

[hw/rtl/diff_drive_odometry.sv]
// Top level: odometry sequencer with shared multiplier, CORDIC, state and ports.
//
// channel | dir | handshake           | payload
// s_axis  | in  | tvalid/tready       | lin_vel, ang_vel
// m_axis  | out | tvalid/tready       | pos_x..ang_vel_echo
// apb     | in  | psel/penable/pready | half_track, time_step, inv_wheel_radius
//
// A result becomes valid after its command has passed the sequencer steps
// (eleven multiplier passes, then the CORDIC start), CORDIC_STEPS rotations
// plus a done step, two more passes and the load of the output register.
// With a free output the next command can be taken in the same cycle that the result is first valid.
// Reset clears pose, wheel angles and registers to defaults.
// A new command is taken while a result waits in the output register;
// the following result holds the sequencer until the output is free.
`timescale 1ns / 1ps
module diff_drive_odometry
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // lin_vel[15:0], ang_vel[31:16]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [175:0] m_axis_tdata,   // pos_x, pos_y, heading_angle,
                                         // left/right_wheel_angle, lin/ang_vel_echo
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    ddo_pkg::cordic_req_t creq;
    ddo_pkg::cordic_rsp_t crsp;
    ddo_cordic u_cordic (.clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));

    localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_CORD = 4'd2, S_OUT = 4'd3;

    logic [3:0] st_reg, st_next;
    logic [3:0] op_reg, op_next;
    logic [15:0] ht_reg, ts_reg, ir_reg;
    logic signed [15:0] v_reg, w_reg;
    logic signed [63:0] x_reg, y_reg;
    logic [31:0] hd_reg, lr_reg, rr_reg;
    logic signed [67:0] p_reg;
    logic signed [63:0] t0_reg, t1_reg, t2_reg, t3_reg;
    logic [37:0] g_reg;
    logic [31:0] hth_reg;
    logic signed [33:0] c_reg, s_reg;
    logic ov_reg;
    logic [175:0] od_reg;
    logic signed [33:0] ma, mb;
    logic signed [67:0] mp;
    logic wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign s_axis_tready = (st_reg == S_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = od_reg;

    always_comb
    begin
        unique case (paddr[3:2])
            ddo_pkg::REG_HALF_TRACK: prdata = {16'd0, ht_reg};
            ddo_pkg::REG_TIME_STEP:  prdata = {16'd0, ts_reg};
            ddo_pkg::REG_INV_RADIUS: prdata = {16'd0, ir_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    function automatic logic signed [63:0] rsh(input logic signed [67:0] v, input int s);
        logic signed [67:0] t;
        begin
            t = (v + (68'sd1 <<< (s - 1))) >>> s;
            return t[63:0];
        end
    endfunction

    function automatic logic signed [63:0] sat(input logic signed [63:0] v);
        logic signed [63:0] hi, lo;
        begin
            hi = (64'sd1 <<< (ddo_pkg::POSITION_WIDTH - 1)) - 64'sd1;
            lo = -hi - 64'sd1;
            return (v > hi) ? hi : ((v < lo) ? lo : v);
        end
    endfunction

    function automatic logic [31:0] o32(input logic signed [63:0] v);
        begin
            return (v > 64'sd2147483647) ? 32'h7fff_ffff :
                   ((v < -64'sd2147483648) ? 32'h8000_0000 : v[31:0]);
        end
    endfunction

    // Operand schedule for the shared multiplier.
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (op_reg)
            4'd0: begin ma = 34'(w_reg); mb = 34'(ht_reg); end
            4'd1: begin ma = 34'(w_reg); mb = 34'(ts_reg); end
            4'd2: begin ma = 34'(ir_reg); mb = 34'(ddo_pkg::ANG_GAIN); end
            4'd3: begin ma = 34'(t2_reg); mb = 34'(ddo_pkg::ANG_GAIN); end
            4'd4: begin ma = 34'(t0_reg); mb = 34'(ts_reg); end
            4'd5: begin ma = 34'(t1_reg); mb = 34'(ts_reg); end
            4'd6: begin ma = 34'(t0_reg); mb = 34'(g_reg[37:19]); end
            4'd7: begin ma = 34'(t0_reg); mb = 34'(g_reg[18:0]); end
            4'd8: begin ma = 34'(t1_reg); mb = 34'(g_reg[37:19]); end
            4'd9: begin ma = 34'(t1_reg); mb = 34'(g_reg[18:0]); end
            4'd10: begin ma = 34'(v_reg); mb = 34'(ts_reg); end
            4'd12: begin ma = t3_reg[33:0]; mb = c_reg; end
            4'd13: begin ma = t3_reg[33:0]; mb = s_reg; end
            default: begin ma = '0; mb = '0; end
        endcase
        mp = ma * mb;
    end

    always_comb
    begin
        st_next = st_reg;
        op_next = op_reg;
        creq.start = 1'b0;
        creq.ang = {2'b00, hd_reg + hth_reg};
        unique case (st_reg)
            S_IDLE: if (s_axis_tvalid && s_axis_tready)
            begin
                st_next = S_MUL;
                op_next = 4'd0;
            end
            S_MUL:
            begin
                op_next = op_reg + 4'd1;
                if (op_reg == 4'd11)
                begin
                    st_next = S_CORD;
                    creq.start = 1'b1;
                end
                if (op_reg == 4'd14) st_next = S_OUT;
            end
            S_CORD: if (crsp.done)
            begin
                st_next = S_MUL;
                op_next = 4'd12;
            end
            S_OUT: if (!ov_reg) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    // Pipeline: p_reg holds product of op_reg-1, consumed while op_reg issues next.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            op_reg <= '0;
            ov_reg <= 1'b0;
            ht_reg <= 16'd11469;
            ts_reg <= 16'd6554;
            ir_reg <= 16'd4267;
            x_reg <= '0;
            y_reg <= '0;
            hd_reg <= '0;
            lr_reg <= '0;
            rr_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            op_reg <= op_next;
            if (wr)
            begin
                unique case (paddr[3:2])
                    ddo_pkg::REG_HALF_TRACK: ht_reg <= pwdata[15:0];
                    ddo_pkg::REG_TIME_STEP:  ts_reg <= pwdata[15:0];
                    ddo_pkg::REG_INV_RADIUS: ir_reg <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (st_reg == S_MUL)
            begin
                case (op_reg)
                    4'd8: lr_reg <= lr_reg + 32'(rsh(68'(t0_reg) + p_reg, 16));
                    4'd10: rr_reg <= rr_reg + 32'(rsh(68'(t1_reg) + p_reg, 16));
                    4'd13: x_reg <= sat(x_reg + rsh(p_reg, 40));
                    4'd14:
                    begin
                        y_reg <= sat(y_reg + rsh(p_reg, 40));
                        hd_reg <= hd_reg + t2_reg[31:0];
                    end
                    default: ;
                endcase
            end
            if (st_reg == S_OUT && !ov_reg)
                ov_reg <= 1'b1;
            else if (ov_reg && m_axis_tready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= mp;
        if (s_axis_tvalid && s_axis_tready)
        begin
            v_reg <= s_axis_tdata[15:0];
            w_reg <= s_axis_tdata[31:16];
        end
        if (st_reg == S_CORD && crsp.done)
        begin
            c_reg <= crsp.cos_val;
            s_reg <= crsp.sin_val;
        end
        if (st_reg == S_MUL)
        begin
            case (op_reg)
                4'd1:
                begin
                    t0_reg <= (64'(v_reg) <<< 16) - p_reg[63:0];
                    t1_reg <= (64'(v_reg) <<< 16) + p_reg[63:0];
                end
                4'd2: t2_reg <= p_reg[63:0];
                4'd3: g_reg <= p_reg[37:0];
                4'd4:
                begin
                    hth_reg <= 32'(rsh(p_reg, 19));
                    t2_reg <= rsh(p_reg, 18);
                end
                4'd5: t0_reg <= rsh(p_reg, 26);
                4'd6: t1_reg <= rsh(p_reg, 26);
                4'd7: t0_reg <= p_reg[63:0] <<< 19;
                4'd9: t1_reg <= p_reg[63:0] <<< 19;
                4'd11: t3_reg <= p_reg[63:0];
                default: ;
            endcase
        end
        if (st_reg == S_OUT && !ov_reg)
            od_reg <= {w_reg, v_reg, rr_reg, lr_reg, hd_reg[31:16], o32(y_reg), o32(x_reg)};
    end

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !m_axis_tready) |=> ov_reg) else $error("word dropped");
    a_start_cord: assert property (@(posedge clk) disable iff (!rst_n)
        creq.start |=> st_reg == S_CORD) else $error("cordic start off sequence");
endmodule
